// ===== rtl/atrp_pkg.sv =====
// Shared types and constants of the AT response parser.
`default_nettype none
package atrp_pkg;

  localparam int LINE_IDX_W = 6;
  localparam int CNT_W      = 7;

  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_O      = 8'h4F;
  localparam logic [7:0] CH_K      = 8'h4B;
  localparam logic [7:0] CH_E      = 8'h45;
  localparam logic [7:0] CH_R      = 8'h52;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] PRINT_LO  = 8'd32;
  localparam logic [7:0] PRINT_HI  = 8'd126;

  typedef enum logic [1:0] {
    ST_BUSY  = 2'd0,
    ST_DONE  = 2'd1,
    ST_ERROR = 2'd2
  } status_t;

  typedef struct packed {
    logic                  char_we;
    logic                  len_we;
    logic [LINE_IDX_W-1:0] line;
    logic [7:0]            col;
    logic [7:0]            data;
  } atrp_wr_t;

  typedef struct packed {
    status_t    status;
    logic       ok;
    logic [4:0] count;
  } atrp_res_t;

endpackage
`default_nettype wire

// ===== rtl/atrp_if.sv =====
// Handshake channels of the AT response parser.
`default_nettype none
interface atrp_in_if;
  logic       valid;
  logic       ready;
  logic       mode;
  logic [7:0] rx_byte;
  logic [3:0] read_line;
  logic [6:0] read_column;

  modport source (output valid, mode, rx_byte, read_line, read_column, input ready);
  modport sink (input valid, mode, rx_byte, read_line, read_column, output ready);
endinterface

interface atrp_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] status;
  logic       response_ok;
  logic [4:0] lines_stored;
  logic [7:0] read_char;
  logic [7:0] read_length;

  modport source (output valid, status, response_ok, lines_stored, read_char, read_length,
                  input ready);
  modport sink (input valid, status, response_ok, lines_stored, read_char, read_length,
                output ready);
endinterface
`default_nettype wire

// ===== rtl/at_response_parser.sv =====
// Top level of the AT response parser: parser, line store memories and result pipeline.
//
//   channel | dir | transfer when       | payload
//   in_ch   | in  | valid && ready      | mode, rx_byte, read_line, read_column
//   out_ch  | out | valid && ready      | status, response_ok, lines_stored, read_char,
//           |     |                     | read_length
//
// One item is accepted per cycle while in_ch.ready is high; its result is registered in the
// memory stage and then in the output register before it is valid on out_ch.
// The parser state updates and the memory write happen in the accept cycle; read-back
// data comes from the registered port of the line store and length memories.
// Reset is synchronous and clears the parser and pipeline; memory contents are not cleared.
// A stalled output holds the memory stage, and in_ch.ready drops only when both are full.
`default_nettype none
module at_response_parser #(
  parameter int MAX_LINES = 16,
  parameter int LINE_SIZE = 128
) (
  input wire logic    clk,
  input wire logic    rst_n,
  atrp_in_if.sink     in_ch,
  atrp_out_if.source  out_ch
);
  import atrp_pkg::*;

  localparam int DEPTH = MAX_LINES * LINE_SIZE;
  localparam int AW    = $clog2(DEPTH);
  localparam int LW    = MAX_LINES > 1 ? $clog2(MAX_LINES) : 1;

  atrp_wr_t         wr;
  atrp_res_t        res;
  logic [CNT_W-1:0] stored_lines;
  logic             accept, feed, s1_adv, hit;
  logic [AW-1:0]    char_waddr, char_raddr;
  logic [7:0]       char_rdata, len_rdata;

  logic             s1_valid_r;
  logic             s1_hit_r;
  logic [6:0]       s1_col_r;
  atrp_res_t        s1_res_r;

  logic             out_valid_r;
  atrp_res_t        out_res_r;
  logic [7:0]       out_char_r, out_len_r;

  assign s1_adv      = !out_valid_r || out_ch.ready;
  assign in_ch.ready = !s1_valid_r || s1_adv;
  assign accept      = in_ch.valid && in_ch.ready;
  assign feed        = accept && !in_ch.mode;

  atrp_parser #(
    .MAX_LINES (MAX_LINES),
    .LINE_SIZE (LINE_SIZE)
  ) u_parser (
    .clk          (clk),
    .rst_n        (rst_n),
    .feed         (feed),
    .rx_byte      (in_ch.rx_byte),
    .wr           (wr),
    .res          (res),
    .stored_lines (stored_lines)
  );

  assign char_waddr = AW'(wr.line) * AW'(LINE_SIZE) + AW'(wr.col);
  assign char_raddr = AW'(in_ch.read_line) * AW'(LINE_SIZE) + AW'(in_ch.read_column);
  assign hit = in_ch.mode && ({3'b000, in_ch.read_line} < stored_lines)
               && ({3'b000, in_ch.read_line} < CNT_W'(MAX_LINES));

  atrp_ram #(
    .WIDTH (8),
    .DEPTH (DEPTH)
  ) u_char_ram (
    .clk   (clk),
    .we    (wr.char_we),
    .waddr (char_waddr),
    .wdata (wr.data),
    .re    (accept && in_ch.mode),
    .raddr (char_raddr),
    .rdata (char_rdata)
  );

  atrp_ram #(
    .WIDTH (8),
    .DEPTH (MAX_LINES)
  ) u_len_ram (
    .clk   (clk),
    .we    (wr.len_we),
    .waddr (LW'(wr.line)),
    .wdata (wr.col),
    .re    (accept && in_ch.mode),
    .raddr (LW'(in_ch.read_line)),
    .rdata (len_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid_r <= accept;
    end
    if (accept) begin
      s1_hit_r <= hit;
      s1_col_r <= in_ch.read_column;
      s1_res_r <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= s1_valid_r;
    end
    if (s1_valid_r && s1_adv) begin
      out_res_r  <= s1_res_r;
      out_len_r  <= s1_hit_r ? len_rdata : 8'd0;
      out_char_r <= (s1_hit_r && ({1'b0, s1_col_r} < len_rdata)) ? char_rdata : 8'd0;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.status       = out_res_r.status;
  assign out_ch.response_ok  = out_res_r.ok;
  assign out_ch.lines_stored = out_res_r.count;
  assign out_ch.read_char    = out_char_r;
  assign out_ch.read_length  = out_len_r;

  a_mem_hold: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && s1_hit_r && !s1_adv |=> $stable(len_rdata))
    else $error("memory read data changed under a stalled stage");
  a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && s1_hit_r |-> len_rdata <= 8'(LINE_SIZE))
    else $error("stored line length beyond line size");
  a_read_busy: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_ch.mode |=> s1_valid_r && s1_res_r.status == ST_BUSY)
    else $error("read-back item reported a parser status");
  a_ready_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ch.ready |-> s1_valid_r && out_valid_r && !out_ch.ready)
    else $error("input stalled with room in the pipeline");

endmodule
`default_nettype wire

// ===== rtl/atrp_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module atrp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                                       clk,
  input  wire logic                                       we,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                           wdata,
  input  wire logic                                       re,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                           rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem_r[raddr];
    end
  end

endmodule
`default_nettype wire

// ===== rtl/atrp_parser.sv =====
// Response syntax state machine with line and column counters.
`default_nettype none
module atrp_parser #(
  parameter int MAX_LINES = 16,
  parameter int LINE_SIZE = 128
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    feed,
  input  wire logic [7:0]              rx_byte,
  output atrp_pkg::atrp_wr_t           wr,
  output atrp_pkg::atrp_res_t          res,
  output logic [atrp_pkg::CNT_W-1:0]   stored_lines
);
  import atrp_pkg::*;

  localparam int CW = $clog2(MAX_LINES + 1);

  typedef enum logic [16:0] {
    S_START    = 17'h00001,
    S_LF0      = 17'h00002,
    S_HEAD     = 17'h00004,
    S_K        = 17'h00008,
    S_OK_CR    = 17'h00010,
    S_OK_LF    = 17'h00020,
    S_E_R1     = 17'h00040,
    S_E_R2     = 17'h00080,
    S_E_O      = 17'h00100,
    S_E_R3     = 17'h00200,
    S_E_CR     = 17'h00400,
    S_E_LF     = 17'h00800,
    S_LINE     = 17'h01000,
    S_LINE_LF  = 17'h02000,
    S_AFTER    = 17'h04000,
    S_BLANK_LF = 17'h08000,
    S_FINAL    = 17'h10000
  } state_t;

  state_t        state_r, state_nxt;
  logic [7:0]    col_r, col_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          ok_r, ok_nxt;
  logic          bad, done, printable, room_line, room_col;

  assign printable = rx_byte inside {[PRINT_LO:PRINT_HI]};
  assign room_line = cnt_r < CW'(MAX_LINES);
  assign room_col  = col_r < 8'(LINE_SIZE);

  always_comb begin
    state_nxt    = state_r;
    col_nxt      = col_r;
    cnt_nxt      = cnt_r;
    ok_nxt       = ok_r;
    bad          = 1'b0;
    done         = 1'b0;
    wr.char_we   = 1'b0;
    wr.len_we    = 1'b0;
    wr.line      = LINE_IDX_W'(cnt_r);
    wr.col       = col_r;
    wr.data      = rx_byte;
    if (feed) begin
      case (state_r)
        S_START: begin
          if (rx_byte == CH_CR) begin
            cnt_nxt   = '0;
            col_nxt   = '0;
            state_nxt = S_LF0;
          end else bad = 1'b1;
        end
        S_LF0: begin
          if (rx_byte == CH_LF) state_nxt = S_HEAD; else bad = 1'b1;
        end
        S_HEAD: begin
          if (rx_byte == CH_O) state_nxt = S_K;
          else if (rx_byte == CH_E) state_nxt = S_E_R1;
          else if (rx_byte == CH_PLUS) begin
            col_nxt   = '0;
            state_nxt = S_LINE;
          end else bad = 1'b1;
        end
        S_K: begin
          if (rx_byte == CH_K) state_nxt = S_OK_CR; else bad = 1'b1;
        end
        S_OK_CR: begin
          if (rx_byte == CH_CR) state_nxt = S_OK_LF; else bad = 1'b1;
        end
        S_OK_LF: begin
          if (rx_byte == CH_LF) begin
            ok_nxt = 1'b1;
            done   = 1'b1;
          end else bad = 1'b1;
        end
        S_E_R1: begin
          if (rx_byte == CH_R) state_nxt = S_E_R2; else bad = 1'b1;
        end
        S_E_R2: begin
          if (rx_byte == CH_R) state_nxt = S_E_O; else bad = 1'b1;
        end
        S_E_O: begin
          if (rx_byte == CH_O) state_nxt = S_E_R3; else bad = 1'b1;
        end
        S_E_R3: begin
          if (rx_byte == CH_R) state_nxt = S_E_CR; else bad = 1'b1;
        end
        S_E_CR: begin
          if (rx_byte == CH_CR) state_nxt = S_E_LF; else bad = 1'b1;
        end
        S_E_LF: begin
          if (rx_byte == CH_LF) begin
            ok_nxt = 1'b0;
            done   = 1'b1;
          end else bad = 1'b1;
        end
        S_LINE: begin
          if (printable) begin
            if (room_line && room_col) begin
              wr.char_we = 1'b1;
              col_nxt    = col_r + 8'd1;
            end
          end else if (rx_byte == CH_CR) begin
            if (room_line) begin
              wr.len_we = 1'b1;
              cnt_nxt   = cnt_r + CW'(1);
            end
            col_nxt   = '0;
            state_nxt = S_LINE_LF;
          end else bad = 1'b1;
        end
        S_LINE_LF: begin
          if (rx_byte == CH_LF) state_nxt = S_AFTER; else bad = 1'b1;
        end
        S_AFTER: begin
          if (rx_byte == CH_PLUS) begin
            col_nxt   = '0;
            state_nxt = S_LINE;
          end else if (rx_byte == CH_CR) state_nxt = S_BLANK_LF;
          else bad = 1'b1;
        end
        S_BLANK_LF: begin
          if (rx_byte == CH_LF) state_nxt = S_FINAL; else bad = 1'b1;
        end
        S_FINAL: begin
          if (rx_byte == CH_O) state_nxt = S_K;
          else if (rx_byte == CH_E) state_nxt = S_E_R1;
          else bad = 1'b1;
        end
        default: bad = 1'b1;
      endcase
      if (bad || done) begin
        state_nxt = S_START;
      end
    end
  end

  always_comb begin
    res.status = bad ? ST_ERROR : (done ? ST_DONE : ST_BUSY);
    res.ok     = ok_nxt;
    res.count  = 5'(cnt_nxt);
  end

  assign stored_lines = CNT_W'(cnt_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_START;
      col_r   <= '0;
      cnt_r   <= '0;
      ok_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      col_r   <= col_nxt;
      cnt_r   <= cnt_nxt;
      ok_r    <= ok_nxt;
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(MAX_LINES)) else $error("line count beyond store");
  a_col_bound: assert property (@(posedge clk) disable iff (!rst_n)
    col_r <= 8'(LINE_SIZE)) else $error("column beyond line size");
  a_end_start: assert property (@(posedge clk) disable iff (!rst_n)
    feed && (bad || done) |=> state_r == S_START) else $error("no return to start");

endmodule
`default_nettype wire

// ===== verif/tb_at_response_parser.sv =====
// Self-checking testbench of the AT response parser with its own parser model and checker.
module tb_at_response_parser;
  timeunit 1ns;
  timeprecision 1ps;

  import atrp_pkg::*;

  localparam int MAX_LINES = 16;
  localparam int LINE_SIZE = 128;
  localparam int ITEMS     = 1200;
  localparam int QUIET     = 150;

  typedef enum logic [4:0] {
    PS_START, PS_LF0, PS_HEAD, PS_K, PS_OK_CR, PS_OK_LF,
    PS_E_R1, PS_E_R2, PS_E_O, PS_E_R3, PS_E_CR, PS_E_LF,
    PS_LINE, PS_LINE_LF, PS_AFTER, PS_BLANK_LF, PS_FINAL
  } parse_t;

  typedef struct packed {
    logic       mode;
    logic [7:0] rx_byte;
    logic [3:0] read_line;
    logic [6:0] read_column;
  } item_t;

  typedef struct packed {
    status_t    status;
    logic       ok;
    logic [4:0] count;
    logic [7:0] rchar;
    logic [7:0] rlen;
  } result_t;

  typedef struct packed {
    item_t   it;
    logic    typed;
    result_t res;
  } dir_row_t;

  localparam result_t NO_RES = '0;

  logic clk;
  logic rst_n;

  atrp_in_if  in_ch();
  atrp_out_if out_ch();

  at_response_parser #(
    .MAX_LINES(MAX_LINES),
    .LINE_SIZE(LINE_SIZE)
  ) dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  parse_t     parse_st;
  logic [7:0] col_idx;
  logic [4:0] stored_cnt;
  logic       ok_flag;
  logic [7:0] line_mem [MAX_LINES][LINE_SIZE];
  logic [7:0] line_len [MAX_LINES];

  result_t    pending_results[$];
  dir_row_t   directed[$];
  logic [7:0] frame[$];

  bit idle_on;
  int n_items;
  int n_checked;
  int n_errors;
  int n_ok;
  int n_err_resp;
  int n_syntax;

  initial clk = 1'b0;
  always #6 clk = ~clk;

  task automatic report_mismatch(input string what);
    n_errors++;
    $display("MISMATCH: %s", what);
  endtask

  function automatic result_t mk_res(input status_t s, input logic ok, input logic [4:0] cnt,
                                     input logic [7:0] ch, input logic [7:0] len);
    result_t r;
    r.status = s;
    r.ok     = ok;
    r.count  = cnt;
    r.rchar  = ch;
    r.rlen   = len;
    return r;
  endfunction

  function automatic item_t feed(input logic [7:0] b);
    item_t it;
    it.mode        = 1'b0;
    it.rx_byte     = b;
    it.read_line   = 4'($urandom);
    it.read_column = 7'($urandom);
    return it;
  endfunction

  function automatic item_t rd(input logic [3:0] l, input logic [6:0] c);
    item_t it;
    it.mode        = 1'b1;
    it.rx_byte     = 8'($urandom);
    it.read_line   = l;
    it.read_column = c;
    return it;
  endfunction

  function automatic item_t pick_read();
    logic [3:0] l;
    logic [6:0] c;
    int         len;
    if (stored_cnt == 0 || $urandom_range(0, 3) == 0) l = 4'($urandom);
    else l = 4'($urandom_range(0, int'(stored_cnt) - 1));
    c = 7'($urandom);
    if (l < stored_cnt && $urandom_range(0, 3) != 0) begin
      len = int'(line_len[l]);
      c = 7'($urandom_range(0, (len > 127) ? 127 : len));
    end
    return rd(l, c);
  endfunction

  task automatic advance_parser(input item_t it, output result_t r);
    parse_t     nxt;
    logic       bad;
    logic       done;
    logic [7:0] c;
    r    = NO_RES;
    nxt  = parse_st;
    bad  = 1'b0;
    done = 1'b0;
    c    = it.rx_byte;
    if (it.mode == 1'b0) begin
      case (parse_st)
        PS_START: begin
          if (c == CH_CR) begin
            stored_cnt = '0;
            col_idx = '0;
            nxt = PS_LF0;
          end else bad = 1'b1;
        end
        PS_LF0: if (c == CH_LF) nxt = PS_HEAD; else bad = 1'b1;
        PS_HEAD: begin
          if (c == CH_O) nxt = PS_K;
          else if (c == CH_E) nxt = PS_E_R1;
          else if (c == CH_PLUS) begin
            col_idx = '0;
            nxt = PS_LINE;
          end else bad = 1'b1;
        end
        PS_K: if (c == CH_K) nxt = PS_OK_CR; else bad = 1'b1;
        PS_OK_CR: if (c == CH_CR) nxt = PS_OK_LF; else bad = 1'b1;
        PS_OK_LF: begin
          if (c == CH_LF) begin
            ok_flag = 1'b1;
            done = 1'b1;
            nxt = PS_START;
          end else bad = 1'b1;
        end
        PS_E_R1: if (c == CH_R) nxt = PS_E_R2; else bad = 1'b1;
        PS_E_R2: if (c == CH_R) nxt = PS_E_O; else bad = 1'b1;
        PS_E_O: if (c == CH_O) nxt = PS_E_R3; else bad = 1'b1;
        PS_E_R3: if (c == CH_R) nxt = PS_E_CR; else bad = 1'b1;
        PS_E_CR: if (c == CH_CR) nxt = PS_E_LF; else bad = 1'b1;
        PS_E_LF: begin
          if (c == CH_LF) begin
            ok_flag = 1'b0;
            done = 1'b1;
            nxt = PS_START;
          end else bad = 1'b1;
        end
        PS_LINE: begin
          if (c inside {[PRINT_LO:PRINT_HI]}) begin
            if (stored_cnt < MAX_LINES && col_idx < LINE_SIZE) begin
              line_mem[stored_cnt][col_idx] = c;
              col_idx = col_idx + 8'd1;
            end
          end else if (c == CH_CR) begin
            if (stored_cnt < MAX_LINES) begin
              line_len[stored_cnt] = col_idx;
              stored_cnt = stored_cnt + 5'd1;
            end
            col_idx = '0;
            nxt = PS_LINE_LF;
          end else bad = 1'b1;
        end
        PS_LINE_LF: if (c == CH_LF) nxt = PS_AFTER; else bad = 1'b1;
        PS_AFTER: begin
          if (c == CH_PLUS) begin
            col_idx = '0;
            nxt = PS_LINE;
          end else if (c == CH_CR) nxt = PS_BLANK_LF;
          else bad = 1'b1;
        end
        PS_BLANK_LF: if (c == CH_LF) nxt = PS_FINAL; else bad = 1'b1;
        PS_FINAL: begin
          if (c == CH_O) nxt = PS_K;
          else if (c == CH_E) nxt = PS_E_R1;
          else bad = 1'b1;
        end
        default: bad = 1'b1;
      endcase
      if (bad) begin
        parse_st = PS_START;
        r.status = ST_ERROR;
      end else begin
        parse_st = nxt;
        r.status = done ? ST_DONE : ST_BUSY;
      end
    end else if (it.read_line < stored_cnt) begin
      r.rlen = line_len[it.read_line];
      if (it.read_column < r.rlen) r.rchar = line_mem[it.read_line][it.read_column];
    end
    r.ok    = ok_flag;
    r.count = stored_cnt;
  endtask

  task automatic send(input item_t it, input logic typed, input result_t typed_res);
    result_t r;
    if (idle_on && $urandom_range(0, 5) == 0) begin
      in_ch.valid = 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk);
    end
    in_ch.valid       = 1'b1;
    in_ch.mode        = it.mode;
    in_ch.rx_byte     = it.rx_byte;
    in_ch.read_line   = it.read_line;
    in_ch.read_column = it.read_column;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    advance_parser(it, r);
    if (r.status == ST_DONE && r.ok) n_ok++;
    else if (r.status == ST_DONE) n_err_resp++;
    else if (r.status == ST_ERROR) n_syntax++;
    pending_results.push_back(typed ? typed_res : r);
    n_items++;
    @(negedge clk);
  endtask

  task automatic add_line(input int len);
    frame.push_back(CH_PLUS);
    repeat (len) frame.push_back(8'($urandom_range(32, 126)));
    frame.push_back(CH_CR);
    frame.push_back(CH_LF);
  endtask

  task automatic build_response(input int nlines, input int long_at, input int maxlen);
    frame.push_back(CH_CR);
    frame.push_back(CH_LF);
    for (int i = 0; i < nlines; i++)
      add_line((i == long_at) ? $urandom_range(128, 131) : $urandom_range(0, maxlen));
    if (nlines > 0) begin
      frame.push_back(CH_CR);
      frame.push_back(CH_LF);
    end
    if ($urandom_range(0, 1) == 0) begin
      frame.push_back(CH_O);
      frame.push_back(CH_K);
    end else begin
      frame.push_back(CH_E);
      frame.push_back(CH_R);
      frame.push_back(CH_R);
      frame.push_back(CH_O);
      frame.push_back(CH_R);
    end
    frame.push_back(CH_CR);
    frame.push_back(CH_LF);
  endtask

  initial begin
    int stall_left;
    stall_left = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        out_ch.ready = 1'b0;
        stall_left--;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        out_ch.ready = 1'b0;
        stall_left = $urandom_range(1, 3) - 1;
      end else begin
        out_ch.ready = 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    result_t exp_r;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("unexpected result status %0d ok %0d count %0d char %02h len %0d",
                                  out_ch.status, out_ch.response_ok, out_ch.lines_stored,
                                  out_ch.read_char, out_ch.read_length));
      end else begin
        exp_r = pending_results.pop_front();
        if (out_ch.status !== exp_r.status || out_ch.response_ok !== exp_r.ok ||
            out_ch.lines_stored !== exp_r.count || out_ch.read_char !== exp_r.rchar ||
            out_ch.read_length !== exp_r.rlen)
          report_mismatch($sformatf(
            "result %0d: got %0d/%0d/%0d/%02h/%0d, expected %0d/%0d/%0d/%02h/%0d", n_checked,
            out_ch.status, out_ch.response_ok, out_ch.lines_stored, out_ch.read_char,
            out_ch.read_length, exp_r.status, exp_r.ok, exp_r.count, exp_r.rchar, exp_r.rlen));
        n_checked++;
      end
    end
  end

  initial begin
    #5_000_000;
    $display("Some tests failed");
    $finish;
  end

  initial begin
    int pick;
    int resp_no;
    int pos;
    int guard;
    n_items = 0;
    n_checked = 0;
    n_errors = 0;
    n_ok = 0;
    n_err_resp = 0;
    n_syntax = 0;
    idle_on = 1'b1;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.mode = 1'b0;
    in_ch.rx_byte = '0;
    in_ch.read_line = '0;
    in_ch.read_column = '0;
    parse_st = PS_START;
    col_idx = '0;
    stored_cnt = '0;
    ok_flag = 1'b0;
    for (int l = 0; l < MAX_LINES; l++) begin
      line_len[l] = '0;
      for (int c = 0; c < LINE_SIZE; c++) line_mem[l][c] = '0;
    end

    directed.push_back('{rd(4'd0, 7'd0), 1'b1, mk_res(ST_BUSY, 1'b0, 5'd0, 8'd0, 8'd0)});
    directed.push_back('{feed(8'hFF), 1'b1, mk_res(ST_ERROR, 1'b0, 5'd0, 8'd0, 8'd0)});
    directed.push_back('{feed(CH_CR), 1'b0, NO_RES});
    directed.push_back('{feed(CH_LF), 1'b0, NO_RES});
    directed.push_back('{feed(CH_PLUS), 1'b0, NO_RES});
    directed.push_back('{feed(8'h41), 1'b0, NO_RES});
    directed.push_back('{feed(PRINT_HI), 1'b0, NO_RES});
    directed.push_back('{feed(PRINT_LO), 1'b0, NO_RES});
    directed.push_back('{feed(CH_CR), 1'b0, NO_RES});
    directed.push_back('{feed(CH_LF), 1'b0, NO_RES});
    directed.push_back('{feed(CH_CR), 1'b0, NO_RES});
    directed.push_back('{feed(CH_LF), 1'b0, NO_RES});
    directed.push_back('{feed(CH_O), 1'b0, NO_RES});
    directed.push_back('{feed(CH_K), 1'b0, NO_RES});
    directed.push_back('{feed(CH_CR), 1'b0, NO_RES});
    directed.push_back('{feed(CH_LF), 1'b1, mk_res(ST_DONE, 1'b1, 5'd1, 8'd0, 8'd0)});
    directed.push_back('{rd(4'd0, 7'd0), 1'b0, NO_RES});
    directed.push_back('{rd(4'd0, 7'd127), 1'b0, NO_RES});
    directed.push_back('{rd(4'd15, 7'd127), 1'b1, mk_res(ST_BUSY, 1'b1, 5'd1, 8'd0, 8'd0)});
    directed.push_back('{feed(CH_CR), 1'b0, NO_RES});
    directed.push_back('{feed(CH_LF), 1'b0, NO_RES});
    directed.push_back('{feed(8'h00), 1'b1, mk_res(ST_ERROR, 1'b1, 5'd0, 8'd0, 8'd0)});

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (directed[i]) send(directed[i].it, directed[i].typed, directed[i].res);

    resp_no = 0;
    while (n_items < ITEMS) begin
      idle_on = (n_items < ITEMS - QUIET) && ($urandom_range(0, 3) != 0);
      frame.delete();
      pick = $urandom_range(0, 99);
      if (resp_no == 0 || pick < 3) build_response($urandom_range(1, 2), 0, 4);
      else if (resp_no == 1 || pick < 6) build_response($urandom_range(16, 18), -1, 2);
      else if (pick < 14) repeat ($urandom_range(1, 4)) frame.push_back(8'($urandom));
      else build_response($urandom_range(0, 3), -1, 6);
      if (pick >= 6 && pick < 14) begin
        if ($urandom_range(0, 1) == 0) send(pick_read(), 1'b0, NO_RES);
      end else if (resp_no > 1 && $urandom_range(0, 99) < 15) begin
        pos = $urandom_range(0, frame.size() - 1);
        frame[pos] = 8'($urandom);
        while (frame.size() > pos + 1) void'(frame.pop_back());
      end
      foreach (frame[i]) send(feed(frame[i]), 1'b0, NO_RES);
      repeat ($urandom_range(0, 4)) send(pick_read(), 1'b0, NO_RES);
      resp_no++;
    end
    in_ch.valid = 1'b0;

    guard = 0;
    while (pending_results.size() != 0 && guard < 20000) begin
      @(posedge clk);
      guard++;
    end
    repeat (10) @(posedge clk);
    if (pending_results.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", pending_results.size()));

    $display("Sent %0d transfers (%0d directed, %0d response frames), checked %0d results.",
             n_items, directed.size(), resp_no, n_checked);
    $display("Responses done with OK: %0d, with ERROR: %0d; syntax errors: %0d.",
             n_ok, n_err_resp, n_syntax);
    if (n_errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/atrp_pkg.sv
rtl/atrp_if.sv
rtl/atrp_ram.sv
rtl/atrp_parser.sv
rtl/at_response_parser.sv
verif/tb_at_response_parser.sv
